// ===== rtl/plane_from_points_macros.svh =====
// Assertion macros shared by the plane_from_points checker.
`ifndef PLANE_FROM_POINTS_MACROS_SVH
`define PLANE_FROM_POINTS_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define PFP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define PFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pfp_pkg.sv =====
// Types, constants and step functions for the plane_from_points pipeline.
package pfp_pkg;

   // Pipeline shape
   localparam int SQ_STAGES  = 16;   // two root bits per stage
   localparam int SQ_BITS    = 32;   // root width
   localparam int DIV_STAGES = 16;   // two quotient bits per stage, one in the last
   localparam int DIV_BITS   = 31;   // quotient width
   localparam logic [30:0] NORM_ONE = 31'h4000_0000;

   typedef struct packed {
      logic               mode;
      logic signed [31:0] p0_x;
      logic signed [31:0] p0_y;
      logic signed [31:0] p0_z;
      logic signed [31:0] p1_x;
      logic signed [31:0] p1_y;
      logic signed [31:0] p1_z;
      logic signed [31:0] p2_x;
      logic signed [31:0] p2_y;
      logic signed [31:0] p2_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] normal_z;
      logic signed [31:0] plane_distance;
      logic               degenerate;
   } rsp_type;

   // Sideband that rides along the square-root pipeline
   typedef struct packed {
      logic signed [2:0][31:0] p0;
      logic [2:0]              neg;
      logic [2:0][30:0]        m;
      logic                    degen;
   } sq_side_type;

   // Sideband that rides along the divider pipeline
   typedef struct packed {
      logic signed [2:0][31:0] p0;
      logic [2:0]              neg;
      logic                    degen;
   } div_side_type;

   typedef struct packed {
      logic [34:0] rem;
      logic [31:0] root;
   } sq_state_type;

   typedef struct packed {
      logic [2:0][61:0] num;
      logic [31:0]      divisor;
   } div_op_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [30:0] quo;
   } div_lane_type;

   // Position of the highest set bit plus one, zero for an all-zero word
   function automatic logic [6:0] bit_length(logic [65:0] v);
      logic [6:0] len;
      len = '0;
      for (int i = 0; i < 66; i++) begin
         if (v[i]) begin
            len = 7'(i + 1);
         end
      end
      return len;
   endfunction

   // One digit-recurrence step of the integer square root
   function automatic sq_state_type sqrt_step(sq_state_type st, logic [1:0] pair);
      sq_state_type nx;
      logic [34:0]  cur;
      logic [34:0]  trial;
      cur   = {st.rem[32:0], pair};
      trial = {1'b0, st.root, 2'b01};
      if (cur >= trial) begin
         nx.rem  = cur - trial;
         nx.root = {st.root[30:0], 1'b1};
      end else begin
         nx.rem  = cur;
         nx.root = {st.root[30:0], 1'b0};
      end
      return nx;
   endfunction

   // One restoring-division step
   function automatic div_lane_type div_step(div_lane_type st, logic nbit, logic [31:0] d);
      div_lane_type nx;
      logic [32:0]  t;
      t = {st.rem, nbit};
      if (t >= {1'b0, d}) begin
         nx.rem = 32'(t - {1'b0, d});
         nx.quo = {st.quo[29:0], 1'b1};
      end else begin
         nx.rem = t[31:0];
         nx.quo = {st.quo[29:0], 1'b0};
      end
      return nx;
   endfunction

endpackage

// ===== rtl/pfp_isqrt.sv =====
// Pipelined 64-bit integer square root, two root bits per stage, with sideband.
module pfp_isqrt import pfp_pkg::*; (
   input  logic                 clock,
   input  logic [SQ_STAGES-1:0] en,
   input  logic [63:0]          sum,
   input  sq_side_type          side_in,
   output logic [SQ_BITS-1:0]   root,
   output sq_side_type          side_out
);

   sq_state_type st_ff   [SQ_STAGES];
   logic [63:0]  sum_ff  [SQ_STAGES];
   sq_side_type  side_ff [SQ_STAGES];

   for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
      localparam int J0 = SQ_BITS - 1 - 2 * k;
      localparam int J1 = SQ_BITS - 2 - 2 * k;
      sq_state_type st_prev;
      sq_state_type st_mid;
      sq_state_type st_in;
      logic [63:0]  sum_prev;
      sq_side_type  side_prev;

      // pick up the previous stage or the pipeline input
      if (k == 0) begin : g_head
         assign st_prev   = '0;
         assign sum_prev  = sum;
         assign side_prev = side_in;
      end else begin : g_body
         assign st_prev   = st_ff[k-1];
         assign sum_prev  = sum_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      assign st_mid = sqrt_step(st_prev, sum_prev[2*J0+1 -: 2]);
      assign st_in  = sqrt_step(st_mid, sum_prev[2*J1+1 -: 2]);

      // advance the stage when the downstream side makes room
      always_ff @(posedge clock) begin
         if (en[k]) begin
            st_ff[k]   <= st_in;
            sum_ff[k]  <= sum_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign root     = st_ff[SQ_STAGES-1].root;
   assign side_out = side_ff[SQ_STAGES-1];

endmodule

// ===== rtl/pfp_div.sv =====
// Pipelined three-lane restoring divider, two quotient bits per stage (one in the last), with sideband.
module pfp_div import pfp_pkg::*; (
   input  logic                       clock,
   input  logic [DIV_STAGES-1:0]      en,
   input  div_op_type                 op,
   input  div_side_type               side_in,
   output logic [2:0][DIV_BITS-1:0]   quo,
   output div_side_type               side_out
);

   div_lane_type [2:0] lane_ff [DIV_STAGES];
   div_op_type         op_ff   [DIV_STAGES];
   div_side_type       side_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      localparam int I0 = DIV_BITS - 1 - 2 * k;
      localparam int I1 = DIV_BITS - 2 - 2 * k;
      div_lane_type [2:0] lane_prev;
      div_lane_type [2:0] lane_mid;
      div_lane_type [2:0] lane_in;
      div_op_type         op_prev;
      div_side_type       side_prev;

      // seed each lane with the numerator bits above the quotient window
      if (k == 0) begin : g_head
         always_comb begin
            for (int i = 0; i < 3; i++) begin
               lane_prev[i].rem = {1'b0, op.num[i][61:31]};
               lane_prev[i].quo = '0;
            end
         end
         assign op_prev   = op;
         assign side_prev = side_in;
      end else begin : g_body
         assign lane_prev = lane_ff[k-1];
         assign op_prev   = op_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            lane_mid[i] = div_step(lane_prev[i], op_prev.num[i][I0], op_prev.divisor);
         end
      end

      // last stage takes a single bit when the quotient width is odd
      if (I1 >= 0) begin : g_two
         always_comb begin
            for (int i = 0; i < 3; i++) begin
               lane_in[i] = div_step(lane_mid[i], op_prev.num[i][I1], op_prev.divisor);
            end
         end
      end else begin : g_one
         assign lane_in = lane_mid;
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            lane_ff[k] <= lane_in;
            op_ff[k]   <= op_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         quo[i] = lane_ff[DIV_STAGES-1][i].quo;
      end
   end
   assign side_out = side_ff[DIV_STAGES-1];

endmodule

// ===== rtl/plane_from_points.sv =====
// Plane from three points (or point and direction): unit normal and distance.
//
// Input channel req_*: one beat carries mode and three Q16.16 points. In
// mode 1 the normal is (p1-p0) x (p2-p0); in mode 0 it is the direction p1.
// Result channel rsp_*: one beat per input beat, in order, with the Q1.30
// unit normal, the saturated Q16.16 distance dot(p0, n) and a degenerate
// flag (zero-length normal, all other fields zero).
// Throughput is one beat per cycle while the receiver does not stall: every
// stage is registered and valid bits travel with the data. The depth is set
// by the 32-bit square root (16 stages, two root bits each) and the
// three-lane divider (16 stages, two quotient bits each, one in the last),
// plus 13 stages of products, shifts and sums.
// Each stage advances when it is empty or its successor advances, so bubbles
// collapse and new beats are taken while a finished result waits; when the
// receiver stalls with every stage full, req_stall rises.
// Reset (synchronous) clears all valid bits; payload registers keep junk.
module plane_from_points import pfp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int SQ_FIRST  = 8;
   localparam int NUM_STG   = SQ_FIRST + SQ_STAGES;
   localparam int DIV_FIRST = NUM_STG + 1;
   localparam int NRM_STG   = DIV_FIRST + DIV_STAGES;
   localparam int DP_STG    = NRM_STG + 1;
   localparam int DOT_STG   = NRM_STG + 2;
   localparam int OUT_STG   = NRM_STG + 3;
   localparam int NST       = OUT_STG + 1;

   logic [NST:0]   en;
   logic [NST-1:0] v_ff, v_in;

   // ---------------- stage control ----------------
   // stage advances when empty or when its successor advances
   always_comb begin
      en[NST] = !rsp_stall;
      for (int k = NST - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_comb begin
      for (int k = 0; k < NST; k++) begin
         if (en[k]) begin
            v_in[k] = (k == 0) ? req_valid : v_ff[(k == 0) ? 0 : k - 1];
         end else begin
            v_in[k] = v_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = v_ff[OUT_STG];

   // ---------------- stage A: edge vectors ----------------
   logic signed [31:0] p0_req [3];
   logic signed [31:0] p1_req [3];
   logic signed [31:0] p2_req [3];
   logic signed [32:0] a_in [3], b_in [3];
   logic signed [32:0] a_ff [3], b_ff [3];
   logic               mode_a_ff, mode_b_ff;
   logic signed [31:0] p1_a_ff [3], p1_b_ff [3];
   logic signed [31:0] p0_ff [5][3];

   assign p0_req = '{req_data.p0_x, req_data.p0_y, req_data.p0_z};
   assign p1_req = '{req_data.p1_x, req_data.p1_y, req_data.p1_z};
   assign p2_req = '{req_data.p2_x, req_data.p2_y, req_data.p2_z};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_in[i] = 33'(p1_req[i]) - 33'(p0_req[i]);
         b_in[i] = 33'(p2_req[i]) - 33'(p0_req[i]);
      end
   end

   // ---------------- stage B: cross-product terms ----------------
   logic signed [65:0] prod_in [6], prod_ff [6];

   assign prod_in[0] = a_ff[1] * b_ff[2];
   assign prod_in[1] = a_ff[2] * b_ff[1];
   assign prod_in[2] = a_ff[2] * b_ff[0];
   assign prod_in[3] = a_ff[0] * b_ff[2];
   assign prod_in[4] = a_ff[0] * b_ff[1];
   assign prod_in[5] = a_ff[1] * b_ff[0];

   // ---------------- stage C: raw normal ----------------
   logic signed [66:0] raw_in [3], raw_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (mode_b_ff) begin
            raw_in[i] = 67'(prod_ff[2*i]) - 67'(prod_ff[2*i+1]);
         end else begin
            raw_in[i] = 67'(p1_b_ff[i]);
         end
      end
   end

   // ---------------- stage D: sign and magnitude ----------------
   logic [65:0] mag_in [3], mag_d_ff [3], mag_e_ff [3];
   logic [2:0]  neg_d_ff, neg_e_ff;

   always_comb begin
      logic [66:0] absv;
      absv = '0;
      for (int i = 0; i < 3; i++) begin
         absv      = raw_ff[i][66] ? (67'd0 - raw_ff[i]) : raw_ff[i];
         mag_in[i] = absv[65:0];
      end
   end

   // ---------------- stage E: common bit length ----------------
   logic [6:0] len_in, len_ff;

   assign len_in = bit_length(mag_d_ff[0] | mag_d_ff[1] | mag_d_ff[2]);

   // ---------------- stage F: normalizing shift ----------------
   sq_side_type side_f_in, side_f_ff, side_g_ff, side_h_ff;

   always_comb begin
      logic [96:0] wide;
      wide = '0;
      for (int i = 0; i < 3; i++) begin
         wide            = {mag_e_ff[i], 31'b0} >> len_ff;
         side_f_in.m[i]  = wide[30:0];
         side_f_in.p0[i] = p0_ff[4][i];
      end
      side_f_in.neg   = neg_e_ff;
      side_f_in.degen = (len_ff == '0);
   end

   // ---------------- stage G: squares ----------------
   logic [61:0] sq_in [3], sq_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = 62'(side_f_ff.m[i]) * 62'(side_f_ff.m[i]);
      end
   end

   // ---------------- stage H: sum of squares ----------------
   logic [63:0] sum_in, sum_ff;

   assign sum_in = 64'(sq_ff[0]) + 64'(sq_ff[1]) + 64'(sq_ff[2]);

   // front registers
   always_ff @(posedge clock) begin
      if (en[0]) begin
         a_ff      <= a_in;
         b_ff      <= b_in;
         mode_a_ff <= req_data.mode;
         p1_a_ff   <= p1_req;
         p0_ff[0]  <= p0_req;
      end
      if (en[1]) begin
         prod_ff   <= prod_in;
         mode_b_ff <= mode_a_ff;
         p1_b_ff   <= p1_a_ff;
         p0_ff[1]  <= p0_ff[0];
      end
      if (en[2]) begin
         raw_ff   <= raw_in;
         p0_ff[2] <= p0_ff[1];
      end
      if (en[3]) begin
         mag_d_ff <= mag_in;
         neg_d_ff <= {raw_ff[2][66], raw_ff[1][66], raw_ff[0][66]};
         p0_ff[3] <= p0_ff[2];
      end
      if (en[4]) begin
         len_ff   <= len_in;
         mag_e_ff <= mag_d_ff;
         neg_e_ff <= neg_d_ff;
         p0_ff[4] <= p0_ff[3];
      end
      if (en[5]) begin
         side_f_ff <= side_f_in;
      end
      if (en[6]) begin
         sq_ff     <= sq_in;
         side_g_ff <= side_f_ff;
      end
      if (en[7]) begin
         sum_ff    <= sum_in;
         side_h_ff <= side_g_ff;
      end
   end

   // ---------------- square root ----------------
   logic [SQ_BITS-1:0] root;
   sq_side_type        sq_side_out;

   pfp_isqrt u_isqrt (
      .clock    (clock),
      .en       (en[SQ_FIRST +: SQ_STAGES]),
      .sum      (sum_ff),
      .side_in  (side_h_ff),
      .root     (root),
      .side_out (sq_side_out)
   );

   // ---------------- numerators with half-divisor rounding ----------------
   div_op_type   op_in, op_ff;
   div_side_type dside_in, dside_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         op_in.num[i] = 62'({sq_side_out.m[i], 30'b0}) + 62'(root >> 1);
      end
      op_in.divisor  = root;
      dside_in.p0    = sq_side_out.p0;
      dside_in.neg   = sq_side_out.neg;
      dside_in.degen = sq_side_out.degen;
   end

   always_ff @(posedge clock) begin
      if (en[NUM_STG]) begin
         op_ff    <= op_in;
         dside_ff <= dside_in;
      end
   end

   // ---------------- division ----------------
   logic [2:0][DIV_BITS-1:0] quo;
   div_side_type             div_side_out;

   pfp_div u_div (
      .clock    (clock),
      .en       (en[DIV_FIRST +: DIV_STAGES]),
      .op       (op_ff),
      .side_in  (dside_ff),
      .quo      (quo),
      .side_out (div_side_out)
   );

   // ---------------- signed unit normal ----------------
   logic signed [31:0] nrm_in [3], nrm_ff [3];
   logic signed [31:0] p0_n_ff [3], p0_in [3];
   logic               degen_n_ff, degen_p_ff, degen_d_ff;

   always_comb begin
      logic [30:0] qc;
      qc = '0;
      for (int i = 0; i < 3; i++) begin
         qc       = (quo[i] > NORM_ONE) ? NORM_ONE : quo[i];
         p0_in[i] = div_side_out.p0[i];
         if (div_side_out.degen) begin
            nrm_in[i] = '0;
         end else if (div_side_out.neg[i]) begin
            nrm_in[i] = 32'sd0 - 32'(qc);
         end else begin
            nrm_in[i] = 32'(qc);
         end
      end
   end

   // ---------------- distance products and sum ----------------
   logic signed [63:0] dp_in [3], dp_ff [3];
   logic signed [65:0] dot_in, dot_ff;
   logic signed [31:0] nx_ff, ny_ff, nz_ff;
   logic signed [31:0] nx2_ff, ny2_ff, nz2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dp_in[i] = p0_n_ff[i] * nrm_ff[i];
      end
   end

   assign dot_in = 66'(dp_ff[0]) + 66'(dp_ff[1]) + 66'(dp_ff[2]);

   always_ff @(posedge clock) begin
      if (en[NRM_STG]) begin
         nrm_ff     <= nrm_in;
         p0_n_ff    <= p0_in;
         degen_n_ff <= div_side_out.degen;
      end
      if (en[DP_STG]) begin
         dp_ff      <= dp_in;
         nx_ff      <= nrm_ff[0];
         ny_ff      <= nrm_ff[1];
         nz_ff      <= nrm_ff[2];
         degen_p_ff <= degen_n_ff;
      end
      if (en[DOT_STG]) begin
         dot_ff     <= dot_in;
         nx2_ff     <= nx_ff;
         ny2_ff     <= ny_ff;
         nz2_ff     <= nz_ff;
         degen_d_ff <= degen_p_ff;
      end
   end

   // ---------------- round, saturate and hold the result ----------------
   rsp_type rsp_in, rsp_ff;

   always_comb begin
      logic [65:0] dmag;
      logic [35:0] qd;
      dmag = dot_ff[65] ? (66'd0 - dot_ff) : dot_ff;
      qd   = 36'((dmag + 66'(32'h2000_0000)) >> 30);
      if (dot_ff[65]) begin
         rsp_in.plane_distance = (qd > 36'h0_8000_0000) ? 32'sh8000_0000
                                                        : 32'(36'd0 - qd);
      end else begin
         rsp_in.plane_distance = (qd > 36'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : qd[31:0];
      end
      rsp_in.normal_x   = nx2_ff;
      rsp_in.normal_y   = ny2_ff;
      rsp_in.normal_z   = nz2_ff;
      rsp_in.degenerate = degen_d_ff;
   end

   always_ff @(posedge clock) begin
      if (en[OUT_STG]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/pfp_checker.sv =====
// Port-level checks for plane_from_points, bound to the top level.
`include "plane_from_points_macros.svh"

module pfp_checker import pfp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result beat holds
   `PFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result beat changed")

   // no result beat right after reset
   `PFP_ASSERT_NOW(a_rsp_reset, clock, 1'b0, $past(reset), !rsp_valid, "result beat right after reset")

   // degenerate beats carry zero fields
   `PFP_ASSERT_NOW(a_degen_zero, clock, reset, rsp_valid && rsp_data.degenerate, rsp_data.normal_x == 0 && rsp_data.normal_y == 0 && rsp_data.normal_z == 0 && rsp_data.plane_distance == 0, "degenerate beat with nonzero fields")

   // a proper normal is never the zero vector
   `PFP_ASSERT_NOW(a_normal_live, clock, reset, rsp_valid && !rsp_data.degenerate, rsp_data.normal_x != 0 || rsp_data.normal_y != 0 || rsp_data.normal_z != 0, "zero normal without degenerate flag")

endmodule

bind plane_from_points pfp_checker u_pfp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for plane_from_points with random handshakes.
module tb_top;
   import pfp_pkg::*;

   localparam int LATENCY    = 45;
   localparam int IDLE_LIMIT = 2000;
   localparam int MAX_SHOWN  = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type expected_planes[$];
   int      mismatches = 0;
   int      idle_cycles = 0;
   int      burst_left = 0;
   int      stall_phase = 0;
   int      stall_left = 0;

   plane_from_points dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Generate the clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Floor of the square root of a 64-bit word, bit by bit
   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned res;
      longint unsigned bit_v;
      res   = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > s) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (s >= res + bit_v) begin
            s   = s - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // Compute the unit normal and distance for one beat
   function automatic rsp_type plane_predict(req_type it);
      logic signed [127:0] p0[3];
      logic signed [127:0] p1[3];
      logic signed [127:0] p2[3];
      logic signed [127:0] a[3];
      logic signed [127:0] b[3];
      logic signed [127:0] raw[3];
      logic [127:0]        mag[3];
      logic                neg[3];
      longint unsigned     m[3];
      longint unsigned     ssum;
      longint unsigned     root;
      longint unsigned     q;
      longint unsigned     dmag;
      longint signed       nrm[3];
      longint signed       dot;
      longint signed       dist_val;
      int                  maxlen;
      rsp_type             o;
      p0[0] = it.p0_x; p0[1] = it.p0_y; p0[2] = it.p0_z;
      p1[0] = it.p1_x; p1[1] = it.p1_y; p1[2] = it.p1_z;
      p2[0] = it.p2_x; p2[1] = it.p2_y; p2[2] = it.p2_z;
      if (it.mode) begin
         for (int i = 0; i < 3; i++) begin
            a[i] = p1[i] - p0[i];
            b[i] = p2[i] - p0[i];
         end
         raw[0] = a[1] * b[2] - a[2] * b[1];
         raw[1] = a[2] * b[0] - a[0] * b[2];
         raw[2] = a[0] * b[1] - a[1] * b[0];
      end else begin
         for (int i = 0; i < 3; i++) raw[i] = p1[i];
      end
      maxlen = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = raw[i] < 0;
         mag[i] = neg[i] ? -raw[i] : raw[i];
         for (int k = 0; k < 128; k++) begin
            if (mag[i][k] && k + 1 > maxlen) maxlen = k + 1;
         end
      end
      o = '0;
      if (maxlen == 0) begin
         o.degenerate = 1'b1;
         return o;
      end
      // Align the largest magnitude to 31 bits and normalize
      ssum = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = (maxlen <= 31) ? 64'(mag[i] << (31 - maxlen)) : 64'(mag[i] >> (maxlen - 31));
         ssum = ssum + m[i] * m[i];
      end
      root = int_sqrt(ssum);
      dot  = 0;
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << 30) + (root >> 1)) / root;
         if (q > 64'd1073741824) q = 64'd1073741824;
         nrm[i] = neg[i] ? -longint'(q) : longint'(q);
         dot    = dot + longint'(p0[i]) * nrm[i];
      end
      // Round half away from zero, then saturate
      dmag = (dot < 0) ? 64'(-dot) : 64'(dot);
      q    = (dmag + (64'd1 << 29)) >> 30;
      if (dot < 0) dist_val = (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
      else         dist_val = (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
      o.normal_x       = nrm[0][31:0];
      o.normal_y       = nrm[1][31:0];
      o.normal_z       = nrm[2][31:0];
      o.plane_distance = dist_val[31:0];
      return o;
   endfunction

   // Drive one beat, hold it until taken, then maybe open a gap
   task automatic send_item(req_type it);
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      expected_planes.push_back(plane_predict(it));
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 30);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   // Random coordinate, mixing full range, small values and extremes
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2:    return $urandom >>> $urandom_range(0, 31);
         3:    return 32'($signed($urandom_range(0, 2000)) - 1000) <<< $urandom_range(0, 16);
         4:    return ($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7fff_ffff;
         default: return 32'(signed'($urandom_range(0, 6)) - 3);
      endcase
   endfunction

   function automatic req_type make_item(logic mode, int p0x, int p0y, int p0z,
                                         int p1x, int p1y, int p1z,
                                         int p2x, int p2y, int p2z);
      req_type it;
      it.mode = mode;
      it.p0_x = p0x; it.p0_y = p0y; it.p0_z = p0z;
      it.p1_x = p1x; it.p1_y = p1y; it.p1_z = p1z;
      it.p2_x = p2x; it.p2_y = p2y; it.p2_z = p2z;
      return it;
   endfunction

   // Extremes of every field, saturation and axis directions
   task automatic test_extremes();
      int mn;
      int mx;
      mn = 32'h8000_0000;
      mx = 32'h7fff_ffff;
      send_item(make_item(1'b0, 0, 0, 0, 65536, 0, 0, 0, 0, 0));
      send_item(make_item(1'b0, mn, 0, 0, -1, 0, 0, 0, 0, 0));
      send_item(make_item(1'b0, mx, mx, mx, 1, 1, 1, mx, mx, mx));
      send_item(make_item(1'b0, mn, mn, mn, mn, mn, mn, mn, mn, mn));
      send_item(make_item(1'b0, mx, mn, mx, mx, mn, mx, 0, 0, 0));
      send_item(make_item(1'b0, -3, 5, 7, 0, mn, 0, -1, -1, -1));
      send_item(make_item(1'b1, mn, mn, mn, mx, mn, mn, mn, mx, mn));
      send_item(make_item(1'b1, mx, mx, mx, mn, mx, mx, mx, mn, mx));
      send_item(make_item(1'b1, mn, mx, mn, mx, mn, mx, mx, mx, mn));
      send_item(make_item(1'b1, 0, 0, 65536, 65536, 0, 65536, 0, 65536, 65536));
      send_item(make_item(1'b1, 1, 2, 3, 4, -5, 6, -7, 8, -9));
      send_item(make_item(1'b1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
   endtask

   // Zero-length normals: zero direction, coincident and collinear points
   task automatic test_degenerate();
      send_item(make_item(1'b0, 12345, -6789, 42, 0, 0, 0, 5, 6, 7));
      send_item(make_item(1'b0, 32'h7fff_ffff, 0, 0, 0, 0, 0, -1, -1, -1));
      send_item(make_item(1'b1, 7, 8, 9, 7, 8, 9, 7, 8, 9));
      send_item(make_item(1'b1, 0, 0, 0, 100, 200, 300, -200, -400, -600));
      send_item(make_item(1'b1, 32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 0, 5, 0, 0));
      send_item(make_item(1'b1, 1, 1, 1, 1, 1, 1, 99, -3, 4));
   endtask

   // Random directions and triangles, with some collinear ones
   task automatic test_random(int count);
      req_type it;
      int      k;
      for (int n = 0; n < count; n++) begin
         it.mode = $urandom_range(0, 3) != 0;
         it.p0_x = rand_coord(); it.p0_y = rand_coord(); it.p0_z = rand_coord();
         it.p1_x = rand_coord(); it.p1_y = rand_coord(); it.p1_z = rand_coord();
         it.p2_x = rand_coord(); it.p2_y = rand_coord(); it.p2_z = rand_coord();
         if (it.mode && $urandom_range(0, 15) == 0) begin
            k = $urandom_range(0, 3) - 2;
            it.p0_x = $signed($urandom_range(0, 20000)) - 10000;
            it.p0_y = $signed($urandom_range(0, 20000)) - 10000;
            it.p0_z = $signed($urandom_range(0, 20000)) - 10000;
            it.p1_x = it.p0_x + 3; it.p1_y = it.p0_y - 5; it.p1_z = it.p0_z + 7;
            it.p2_x = it.p0_x + 3 * k; it.p2_y = it.p0_y - 5 * k; it.p2_z = it.p0_z + 7 * k;
         end else if (!it.mode && $urandom_range(0, 30) == 0) begin
            it.p1_x = 0; it.p1_y = 0; it.p1_z = 0;
         end
         send_item(it);
      end
   endtask

   // Receiver stall pattern: free runs, sparse stalls, long holds
   always @(posedge clock) begin
      if (stall_left <= 0) begin
         stall_phase = $urandom_range(0, 3);
         stall_left  = $urandom_range(5, 80);
      end
      stall_left--;
      case (stall_phase)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) != 0);
      endcase
   end

   // Check each accepted result beat against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_planes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) $display("unexpected result beat %h", rsp_data);
         end else begin
            want = expected_planes.pop_front();
            if (rsp_data.normal_x !== want.normal_x || rsp_data.normal_y !== want.normal_y ||
                rsp_data.normal_z !== want.normal_z ||
                rsp_data.plane_distance !== want.plane_distance ||
                rsp_data.degenerate !== want.degenerate) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN) begin
                  $display("mismatch: exp n=(%0d,%0d,%0d) d=%0d dg=%b",
                           want.normal_x, want.normal_y, want.normal_z,
                           want.plane_distance, want.degenerate);
                  $display("          got n=(%0d,%0d,%0d) d=%0d dg=%b",
                           rsp_data.normal_x, rsp_data.normal_y, rsp_data.normal_z,
                           rsp_data.plane_distance, rsp_data.degenerate);
               end
            end
         end
      end
   end

   // Watchdog on cycles without any beat moving
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Run the tests in turn, then drain
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      burst_left = $urandom_range(1, 30);
      test_extremes();
      test_degenerate();
      test_random(1100);
      req_valid <= 1'b0;
      while (expected_planes.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && expected_planes.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/pfp_pkg.sv
rtl/pfp_isqrt.sv
rtl/pfp_div.sv
rtl/plane_from_points.sv
rtl/pfp_checker.sv
tb/sv/tb_top.sv
